// ===== rtl/core/lmh_pkg.sv =====
// Shared types and constants for the label mode histogram block.
`default_nettype none

package lmh_pkg;

   localparam int LABEL_W           = 8;
   localparam int COUNT_OUT_W       = 16;
   localparam int LABEL_COUNT_W     = 9;
   localparam logic [LABEL_COUNT_W-1:0] LABEL_COUNT_RESET = 9'd256;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_RUN,
      ST_SCAN,
      ST_FINISH
   } lmh_state_type;

   // control from the sequencer to the arg-max tracker
   typedef struct packed {
      logic start;    // new search, best resets to label 0 / count 0
      logic sample;   // read data of one entry is valid this cycle
   } argmax_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/lmh_count_ram.sv =====
// Histogram count memory: one write port, one read port, registered read.
`default_nettype none

module lmh_count_ram #(
   parameter int DEPTH  = 256,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lmh_argmax.sv =====
// Running arg-max over histogram entries read out one per cycle.
`default_nettype none

module lmh_argmax
   import lmh_pkg::*;
#(
   parameter int IDX_W       = 8,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire argmax_ctl_type           ctl,
   input  wire logic [IDX_W-1:0]         sample_idx,
   input  wire logic [COUNT_WIDTH-1:0]   sample_cnt,
   input  wire logic [LABEL_COUNT_W-1:0] limit,
   output logic      [IDX_W-1:0]         best_idx,
   output logic      [COUNT_WIDTH-1:0]   best_cnt
);

   localparam int CW = ((IDX_W > LABEL_COUNT_W) ? IDX_W : LABEL_COUNT_W) + 1;

   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [COUNT_WIDTH-1:0] best_cnt_ff, best_cnt_in;
   logic                   in_limit;

   assign in_limit = (CW'(sample_idx) < CW'(limit));

   // strict greater keeps the lowest label on ties
   always_comb begin
      best_idx_in = best_idx_ff;
      best_cnt_in = best_cnt_ff;
      if (ctl.start) begin
         best_idx_in = '0;
         best_cnt_in = '0;
      end else if (ctl.sample && in_limit && (sample_cnt > best_cnt_ff)) begin
         best_idx_in = sample_idx;
         best_cnt_in = sample_cnt;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_cnt_ff <= best_cnt_in;
   end

   assign best_idx = best_idx_in;
   assign best_cnt = best_cnt_in;

endmodule

`default_nettype wire

// ===== rtl/core/label_mode_histogram.sv =====
// Top level of the label mode histogram: intake, count update, scan and result.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+---------------------------------------
//   req     | in  | req_tvalid/req_tready  | tdata: label; tlast: last_point
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata: mode_label, mode_count; tuser: ignored_seen
//   csr     | in  | csr_we                 | csr_wdata: label_count
//
// Cycles: one label per cycle while a set streams in. Each label does a
// read-modify-write of its count in the histogram memory; a one-entry
// forwarding register covers back-to-back hits on the same label.
// After the last label of a set, intake stops while the last count is
// written, every entry is read and cleared (one memory port each way)
// and the search is closed; closing waits for a free output register.
// Reset: a clearing pass over every entry zeroes the memory; no label
// is taken until it ends, csr writes are taken at any time.
// Stalls: a finished result waits in the output register while the next set
// streams in; only the end of the following set's scan waits on rsp_tready.
`default_nettype none

module label_mode_histogram
   import lmh_pkg::*;
#(
   parameter int NUM_LABELS  = 256,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request stream
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [7:0]               req_tdata,   // [7:0] label
   input  wire logic                     req_tlast,   // last_point
   // result stream
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [23:0]              rsp_tdata,   // [7:0] mode_label, [23:8] mode_count
   output logic                          rsp_tuser,   // [0] ignored_seen
   // configuration
   input  wire logic                     csr_we,
   input  wire logic [LABEL_COUNT_W-1:0] csr_wdata    // label_count
);

   localparam int IDX_W = $clog2(NUM_LABELS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LABELS - 1);

   // ---------------- configuration register
   logic [LABEL_COUNT_W-1:0] label_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         label_count_ff <= LABEL_COUNT_RESET;
      end else if (csr_we) begin
         label_count_ff <= csr_wdata;
      end
   end

   // ---------------- sequencer state
   lmh_state_type   state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             addr_at_end;

   // ---------------- intake and update stage
   logic             accept;
   logic [LABEL_W-1:0] req_label;
   logic             req_label_ok;
   logic             s1_valid_ff;
   logic [IDX_W-1:0] s1_addr_ff;
   logic             s1_ok_ff;
   logic             s1_last_ff;
   logic             s1_end;          // last label of a set is in the update stage

   // ---------------- memory ports
   logic [IDX_W-1:0]       rd_addr;
   logic [COUNT_WIDTH-1:0] rd_data;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;

   // forwarding of the write that lands on the same edge as a read
   logic                   fwd_valid_ff;
   logic [IDX_W-1:0]       fwd_addr_ff;
   logic [COUNT_WIDTH-1:0] fwd_data_ff;
   logic [COUNT_WIDTH-1:0] cur_count;
   logic [COUNT_WIDTH-1:0] inc_count;

   // ---------------- scan and result
   logic             cmp_valid_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   argmax_ctl_type   amx_ctl;
   logic [IDX_W-1:0]       best_idx;
   logic [COUNT_WIDTH-1:0] best_cnt;
   logic [31:0]            best_cnt_ext;
   logic             ign_ff;
   logic             ign_res_ff;
   logic             out_free;
   logic             rsp_valid_ff;
   logic [23:0]      rsp_data_ff;
   logic             rsp_user_ff;

   assign req_label    = req_tdata[LABEL_W-1:0];
   assign req_tready   = (state_ff == ST_RUN) && !(s1_valid_ff && s1_last_ff);
   assign accept       = req_tvalid && req_tready;
   // a label counts only below label_count and below the memory depth
   assign req_label_ok = ({1'b0, req_label} < label_count_ff) &&
                         (32'(req_label) < 32'(NUM_LABELS));
   assign s1_end       = s1_valid_ff && s1_last_ff;
   assign addr_at_end  = (addr_ff == LAST_IDX);
   assign out_free     = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_addr_ff <= IDX_W'(req_label);
         s1_ok_ff   <= req_label_ok;
         s1_last_ff <= req_tlast;
      end
   end

   // saturating increment, newest value taken from the forwarding register
   assign cur_count = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rd_data;
   assign inc_count = (cur_count == {COUNT_WIDTH{1'b1}}) ? cur_count
                                                          : cur_count + COUNT_WIDTH'(1);

   // ---------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT:   if (addr_at_end) state_in = ST_RUN;
         ST_RUN:    if (s1_end) state_in = ST_SCAN;
         ST_SCAN:   if (addr_at_end) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_RUN;
         default:   state_in = ST_INIT;
      endcase
   end

   // ---------------- sequencer outputs
   always_comb begin
      addr_in = addr_ff;
      rd_addr = IDX_W'(req_label);
      wr_en   = 1'b0;
      wr_addr = s1_addr_ff;
      wr_data = inc_count;
      amx_ctl = '{start: 1'b0, sample: cmp_valid_ff};
      case (state_ff)
         ST_INIT: begin
            addr_in = addr_at_end ? '0 : addr_ff + IDX_W'(1);
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            wr_data = '0;
         end
         ST_RUN: begin
            wr_en         = s1_valid_ff && s1_ok_ff;
            amx_ctl.start = s1_end;
         end
         ST_SCAN: begin
            // read and clear the same entry; the read returns the old count
            addr_in = addr_at_end ? '0 : addr_ff + IDX_W'(1);
            rd_addr = addr_ff;
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            wr_data = '0;
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         addr_ff      <= '0;
         fwd_valid_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         fwd_valid_ff <= wr_en;
         cmp_valid_ff <= (state_ff == ST_SCAN);
      end
      fwd_addr_ff <= wr_addr;
      fwd_data_ff <= wr_data;
      cmp_idx_ff  <= addr_ff;
   end

   lmh_count_ram #(
      .DEPTH  (NUM_LABELS),
      .WIDTH  (COUNT_WIDTH),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   lmh_argmax #(
      .IDX_W       (IDX_W),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_argmax (
      .clock      (clock),
      .ctl        (amx_ctl),
      .sample_idx (cmp_idx_ff),
      .sample_cnt (rd_data),
      .limit      (label_count_ff),
      .best_idx   (best_idx),
      .best_cnt   (best_cnt)
   );

   // ---------------- ignored flag, latched for the result at end of set
   always_ff @(posedge clock) begin
      if (reset) begin
         ign_ff <= 1'b0;
      end else if (s1_end) begin
         ign_ff <= 1'b0;
      end else if (s1_valid_ff && !s1_ok_ff) begin
         ign_ff <= 1'b1;
      end
      if (s1_end) begin
         ign_res_ff <= ign_ff || !s1_ok_ff;
      end
   end

   // ---------------- result register
   assign best_cnt_ext = 32'(best_cnt);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_FINISH) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_data_ff[7:0]  <= LABEL_W'(best_idx);
         rsp_data_ff[23:8] <= (best_cnt_ext > 32'h0000_FFFF) ? 16'hFFFF
                                                              : best_cnt_ext[15:0];
         rsp_user_ff       <= ign_res_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---------------- assertions
   a_update_only_in_run: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (state_ff == ST_RUN))
      else $error("count update outside the run state");

   a_scan_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      s1_end |=> (state_ff == ST_SCAN) && (addr_ff == '0))
      else $error("scan did not start at entry zero after the last label");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && out_free |=> rsp_valid_ff && (state_ff == ST_RUN))
      else $error("finished search did not produce a result");

   a_no_intake_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !accept && !s1_valid_ff)
      else $error("label taken while the histogram is being scanned");

endmodule

`default_nettype wire

// ===== tb/mode_vote_checker.sv =====
`timescale 1ns / 1ps
// Checker for label_mode_histogram: watches the streams, predicts each vote and compares.

module mode_vote_checker
   import lmh_pkg::*;
#(
   parameter int NUM_LABELS  = 256,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   input  wire logic                     req_tready,
   input  wire logic [LABEL_W-1:0]       req_tdata,
   input  wire logic                     req_tlast,
   input  wire logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire logic [23:0]              rsp_tdata,
   input  wire logic                     rsp_tuser,
   input  wire logic                     csr_we,
   input  wire logic [LABEL_COUNT_W-1:0] csr_wdata,
   output int                            votes_pending,
   output int                            vote_errors
);

   typedef struct packed {
      logic [LABEL_W-1:0]     mode_label;
      logic [COUNT_OUT_W-1:0] mode_count;
      logic                   ignored_seen;
   } vote_type;

   logic [COUNT_WIDTH-1:0]   label_tally [NUM_LABELS];
   logic                     any_ignored;
   logic [LABEL_COUNT_W-1:0] label_limit;
   vote_type                 expected_votes [$];
   int                       error_total = 0;

   // count one label; on the last one of a set, search and queue the vote
   task automatic tally_label(input logic [LABEL_W-1:0] lab, input logic last);
      int unsigned active;
      int unsigned best_label;
      int unsigned best_count;
      vote_type    vote;
      active = (32'(label_limit) > NUM_LABELS) ? NUM_LABELS : 32'(label_limit);
      if (lab < active) begin
         if (label_tally[lab] != {COUNT_WIDTH{1'b1}})
            label_tally[lab] = label_tally[lab] + COUNT_WIDTH'(1);
      end else begin
         any_ignored = 1'b1;
      end
      if (last) begin
         best_label = 0;
         best_count = 0;
         // strict greater keeps the lowest label on ties
         for (int i = 0; i < active; i++) begin
            if (32'(label_tally[i]) > best_count) begin
               best_count = 32'(label_tally[i]);
               best_label = i;
            end
         end
         vote.mode_label   = best_label[LABEL_W-1:0];
         vote.mode_count   = (best_count > 32'hFFFF) ? 16'hFFFF : best_count[15:0];
         vote.ignored_seen = any_ignored;
         expected_votes.push_back(vote);
         foreach (label_tally[i]) label_tally[i] = '0;
         any_ignored = 1'b0;
      end
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_total++;
      end
   endtask

   always @(posedge clock) begin : monitor
      vote_type want;
      if (reset) begin
         foreach (label_tally[i]) label_tally[i] = '0;
         any_ignored = 1'b0;
         label_limit = LABEL_COUNT_RESET;
         expected_votes.delete();
      end else begin
         // a register write lands at this edge and applies from the next transfer on
         if (req_tvalid && req_tready)
            tally_label(req_tdata, req_tlast);
         if (csr_we)
            label_limit = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_votes.size() == 0) begin
               $error("unexpected result: mode_label %0d, mode_count %0d, ignored_seen %0d",
                      rsp_tdata[7:0], rsp_tdata[23:8], rsp_tuser);
               error_total++;
            end else begin
               want = expected_votes.pop_front();
               check_field("mode_label", 32'(want.mode_label), 32'(rsp_tdata[7:0]));
               check_field("mode_count", 32'(want.mode_count), 32'(rsp_tdata[23:8]));
               check_field("ignored_seen", 32'(want.ignored_seen), 32'(rsp_tuser));
            end
         end
      end
      votes_pending <= expected_votes.size();
      vote_errors   <= error_total;
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the label_mode_histogram testbench: clock, reset, stimulus and verdict.

module testbench;
   import lmh_pkg::*;

   localparam int NUM_LABELS  = 256;
   localparam int COUNT_WIDTH = 16;
   // drain wait covers the scan and clear of every entry after a set; leave headroom
   localparam int DRAIN_CYCLES = NUM_LABELS + 16;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [LABEL_W-1:0]       req_tdata  = '0;    // [7:0] label
   logic                     req_tlast  = 1'b0;  // last_point
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [23:0]              rsp_tdata;          // [7:0] mode_label, [23:8] mode_count
   logic                     rsp_tuser;          // [0] ignored_seen
   logic                     csr_we     = 1'b0;
   logic [LABEL_COUNT_W-1:0] csr_wdata  = '0;    // label_count

   int votes_pending;
   int vote_errors;

   // idle odds in percent per cycle, changed between phases
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   label_mode_histogram #(
      .NUM_LABELS (NUM_LABELS),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   mode_vote_checker #(
      .NUM_LABELS (NUM_LABELS),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .votes_pending(votes_pending),
      .vote_errors  (vote_errors)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: backpressure redrawn every cycle from the current odds
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // hard stop in case the block hangs
   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

   // One label transfer. Random idle cycles go before it; with no idling
   // valid simply stays high and only the payload changes.
   task automatic send_label(input logic [LABEL_W-1:0] lab, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= lab;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid, wait for every queued vote, then let the scan pipeline settle.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (votes_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_label_count(input logic [LABEL_COUNT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Random sets: mostly labels from a small per-set pool below the limit,
   // so counts pile up and ties happen; the rest are any label, which
   // covers every bit and the ignored path.
   task automatic random_sets(input logic [LABEL_COUNT_W-1:0] label_count, input int n_items);
      int            sent;
      int            set_len;
      int unsigned   active;
      logic [LABEL_W-1:0] pool [4];
      logic [LABEL_W-1:0] lab;
      wait_drain();
      write_label_count(label_count);
      active = (32'(label_count) > NUM_LABELS) ? NUM_LABELS : 32'(label_count);
      sent = 0;
      while (sent < n_items) begin
         set_len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         foreach (pool[i])
            pool[i] = (active != 0) ? LABEL_W'($urandom_range(0, active - 1))
                                    : LABEL_W'($urandom_range(0, 255));
         for (int k = 0; k < set_len; k++) begin
            if (active != 0 && $urandom_range(0, 9) < 8)
               lab = pool[2'($urandom_range(0, 3))];
            else
               lab = LABEL_W'($urandom_range(0, 255));
            send_label(lab, k == set_len - 1);
         end
         sent += set_len;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // sender idles a third of the time, receiver two thirds
      send_idle_pct = 33;
      rsp_stall_pct = 67;

      // directed: label count still at its reset value
      send_label(8'd0, 1'b1);            // lowest label alone
      send_label(8'd255, 1'b1);          // highest label alone
      send_label(8'd7, 1'b0);            // tie between 3 and 7, lower wins
      send_label(8'd3, 1'b0);
      send_label(8'd3, 1'b0);
      send_label(8'd7, 1'b1);

      wait_drain();
      write_label_count(9'd10);
      send_label(8'd200, 1'b0);          // nothing valid: zero vote, ignored
      send_label(8'd12, 1'b1);
      send_label(8'd9, 1'b0);            // last item out of range still closes the set
      send_label(8'd10, 1'b1);

      wait_drain();
      write_label_count(9'd0);           // every label ignored
      send_label(8'd0, 1'b1);

      wait_drain();
      write_label_count(9'd511);         // beyond the table, acts as full size
      send_label(8'd255, 1'b0);
      send_label(8'd255, 1'b0);
      send_label(8'd0, 1'b1);

      // limit lowered in the middle of a set: the search stops below it
      wait_drain();
      write_label_count(9'd256);
      send_label(8'd200, 1'b0);
      send_label(8'd200, 1'b0);
      send_label(8'd200, 1'b0);
      send_label(8'd4, 1'b0);
      wait_drain();
      write_label_count(9'd100);
      send_label(8'd4, 1'b1);

      // the entry above the old limit must have been cleared too
      wait_drain();
      write_label_count(9'd256);
      send_label(8'd200, 1'b1);

      // random part, three idling regimes
      send_idle_pct = 33;
      rsp_stall_pct = 67;
      random_sets(9'd256, 100);
      random_sets(9'($urandom_range(2, 254)), 100);

      send_idle_pct = 67;
      rsp_stall_pct = 33;
      random_sets(9'd1, 100);
      random_sets(9'd511, 100);

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      random_sets(9'($urandom_range(128, 300)), 100);
      random_sets(9'd255, 100);

      wait_drain();
      if (vote_errors == 0 && votes_pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== label_mode_histogram.f =====
rtl/core/lmh_pkg.sv
rtl/core/lmh_count_ram.sv
rtl/core/lmh_argmax.sv
rtl/core/label_mode_histogram.sv
tb/mode_vote_checker.sv
tb/testbench.sv
